// ===== src/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg: shared constants and types for the rtd temperature pipeline
// Fixed-point constants of the inverse quadratic and the pipeline types.
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int AdcBits = 24;
   localparam int Sh      = 51 - AdcBits;      // 27

   localparam logic [23:0] R0Default = 24'd1000000;
   localparam logic [63:0] KQ28      = 64'd1758480889 << 28;
   localparam logic [31:0] CvdTerm   = 32'd451171875;
   localparam logic [63:0] AQ14      = 64'd39083 * 64'd16384;
   localparam logic [63:0] TDen      = 64'd231 * 64'd16384;
   localparam logic [63:0] BigLimit  = 64'd1 << (61 - Sh);

   localparam logic signed [22:0] TMin = -23'sd4000000;
   localparam logic signed [22:0] TMax = 23'sd4000000;
   localparam logic signed [22:0] TErr = -23'sd1000000;

   // dividend of the quotient stage: 56 bits covers term * mag
   localparam int QW = 56;
   // divider steps, QW+Sh quotient bits after shift-in of Sh extra bits
   localparam int DivSteps = QW + Sh;          // 83
   // square root steps on 64-bit radicand
   localparam int SqSteps = 32;

   typedef struct packed {
      logic       neg;
      logic [QW-1:0] q;
      logic [23:0] r0;
   } div_in_type;

   typedef struct packed {
      logic       valid;
      logic       neg;
      logic       big;
      logic [63:0] tq;
   } div_out_type;

   typedef struct packed {
      logic       valid;
      logic       sel;          // 0 normal, 1 forced result
      logic       flag;
      logic signed [22:0] forced;
      logic [63:0] x;
   } sq_in_type;

endpackage

// ===== src/rtd_div.sv =====
// ----------------------------------------------------------------------------
// rtd_div: pipelined restoring divider
// Computes (term*mag << Sh) / r0 one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtd_div
   import rtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  div_in_type  in_data,
   output div_out_type out_data
);

   localparam int NW = QW + Sh;

   logic [DivSteps:0]         v_ff;
   logic [DivSteps:0]         n_ff;
   logic [NW-1:0]             num_ff [DivSteps+1];
   logic [24:0]               rem_ff [DivSteps+1];
   logic [23:0]               d_ff   [DivSteps+1];
   logic [NW-1:0]             quo_ff [DivSteps+1];

   // stage zero loads the shifted dividend
   always_ff @(posedge clock) begin
      num_ff[0] <= {in_data.q, {Sh{1'b0}}};
      rem_ff[0] <= '0;
      quo_ff[0] <= '0;
      d_ff[0]   <= in_data.r0;
      n_ff[0]   <= in_data.neg;
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
   end

   // one quotient bit per stage
   for (genvar i = 0; i < DivSteps; i++) begin : g_step
      logic [25:0] tr;
      logic [25:0] df;
      assign tr = {rem_ff[i], num_ff[i][NW-1]};
      assign df = tr - {2'b0, d_ff[i]};
      always_ff @(posedge clock) begin
         num_ff[i+1] <= {num_ff[i][NW-2:0], 1'b0};
         d_ff[i+1]   <= d_ff[i];
         n_ff[i+1]   <= n_ff[i];
         if (!df[25]) begin
            rem_ff[i+1] <= df[24:0];
            quo_ff[i+1] <= {quo_ff[i][NW-2:0], 1'b1};
         end else begin
            rem_ff[i+1] <= tr[24:0];
            quo_ff[i+1] <= {quo_ff[i][NW-2:0], 1'b0};
         end
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
      end
   end

   // big test on the integer part of the quotient
   logic [NW-1:0] qf;
   assign qf = quo_ff[DivSteps];
   assign out_data.valid = v_ff[DivSteps];
   assign out_data.neg   = n_ff[DivSteps];
   assign out_data.big   = ({{(64-QW){1'b0}}, qf[NW-1:Sh]} > BigLimit);
   assign out_data.tq    = qf[63:0];

endmodule

// ===== src/rtd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rtd_sqrt: pipelined integer square root and final scaling
// One result bit per stage, then the rounded divide by a constant.
// ----------------------------------------------------------------------------
module rtd_sqrt
   import rtd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  sq_in_type           in_data,
   output logic                out_valid,
   output logic signed [22:0]  out_temp,
   output logic                out_flag
);

   logic [SqSteps:0] v_ff;
   logic [SqSteps:0] sel_ff;
   logic [SqSteps:0] fl_ff;
   logic signed [22:0] fo_ff [SqSteps+1];
   logic [63:0] x_ff [SqSteps+1];
   logic [33:0] rem_ff [SqSteps+1];
   logic [31:0] root_ff [SqSteps+1];

   always_ff @(posedge clock) begin
      x_ff[0]    <= in_data.x;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      sel_ff[0]  <= in_data.sel;
      fl_ff[0]   <= in_data.flag;
      fo_ff[0]   <= in_data.forced;
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_data.valid;
   end

   // digit-by-digit root, two radicand bits per stage
   for (genvar i = 0; i < SqSteps; i++) begin : g_step
      logic [35:0] tr;
      logic [35:0] tt;
      assign tr = {rem_ff[i], x_ff[i][63:62]};
      assign tt = {2'b0, root_ff[i], 2'b01};
      always_ff @(posedge clock) begin
         x_ff[i+1]   <= {x_ff[i][61:0], 2'b00};
         sel_ff[i+1] <= sel_ff[i];
         fl_ff[i+1]  <= fl_ff[i];
         fo_ff[i+1]  <= fo_ff[i];
         if (tr >= tt) begin
            rem_ff[i+1]  <= 34'(tr - tt);
            root_ff[i+1] <= {root_ff[i][30:0], 1'b1};
         end else begin
            rem_ff[i+1]  <= tr[33:0];
            root_ff[i+1] <= {root_ff[i][30:0], 1'b0};
         end
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
      end
   end

   // num2 = 2*(A - s)*20000 + TDen, kept as signed
   logic               va_ff, sa_ff, fa_ff;
   logic signed [22:0] foa_ff;
   logic signed [48:0] n2_ff;
   always_ff @(posedge clock) begin
      n2_ff  <= (49'(signed'({1'b0, AQ14[31:0]})) - 49'(signed'({1'b0, root_ff[SqSteps]})))
                * 49'sd40000 + 49'(signed'({1'b0, TDen[31:0]}));
      sa_ff  <= sel_ff[SqSteps];
      fa_ff  <= fl_ff[SqSteps];
      foa_ff <= fo_ff[SqSteps];
      if (reset) va_ff <= 1'b0;
      else va_ff <= v_ff[SqSteps];
   end

   // floor divide by 2*TDen = 231 * 2^15: shift then divide by 231 via reciprocal
   logic signed [33:0] hi;
   assign hi = 34'(n2_ff >>> 15);
   logic               vb_ff, sb_ff, fb_ff;
   logic signed [22:0] fob_ff;
   logic signed [33:0] hi_ff;
   always_ff @(posedge clock) begin
      hi_ff  <= hi;
      sb_ff  <= sa_ff;
      fb_ff  <= fa_ff;
      fob_ff <= foa_ff;
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
   end

   // reciprocal estimate of hi/231, off by at most one either way
   logic signed [67:0] pr;
   assign pr = hi_ff * 68'sd18592932;         // floor(2^32/231)
   logic               vc_ff, sc_ff, fc_ff;
   logic signed [22:0] foc_ff;
   logic signed [33:0] hc_ff;
   logic signed [33:0] qe_ff;
   always_ff @(posedge clock) begin
      hc_ff  <= hi_ff;
      qe_ff  <= 34'(pr >>> 32);
      sc_ff  <= sb_ff;
      fc_ff  <= fb_ff;
      foc_ff <= fob_ff;
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
   end

   // correct the estimate by one either way
   logic signed [33:0] rm;
   logic signed [33:0] qq;
   assign rm = hc_ff - qe_ff * 34'sd231;
   always_comb begin
      qq = qe_ff;
      if (rm >= 34'sd231) qq = qe_ff + 34'sd1;
      else if (rm < 34'sd0) qq = qe_ff - 34'sd1;
   end

   always_ff @(posedge clock) begin
      if (sc_ff) out_temp <= foc_ff;
      else if (qq < 34'(TMin)) out_temp <= TMin;
      else if (qq > 34'(TMax)) out_temp <= TMax;
      else out_temp <= qq[22:0];
      out_flag <= fc_ff;
      if (reset) out_valid <= 1'b0;
      else out_valid <= vc_ff;
   end

endmodule

// ===== src/rtd_adc_code_to_temperature_top.sv =====
// ----------------------------------------------------------------------------
// rtd_adc_code_to_temperature_top: rtd code to millidegrees
// Inverse Callendar-Van Dusen for t >= 0, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                         direction
//  request   start, busy, req_raw_code     in (busy out)
//  result    rsp_valid, rsp_temp_millideg,
//            rsp_out_of_range              out (strobe)
//  csr       csr_valid, csr_ready, csr_r0_milliohm  in (csr_ready out)
//
// one request per cycle, through the bit-per-stage divider and square-root
// pipelines. busy is held low, the result side never stalls. reset clears
// valid bits and sets r0 to 1000 ohm.
module rtd_adc_code_to_temperature_top
   import rtd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_raw_code,
   output logic               rsp_valid,
   output logic signed [22:0] rsp_temp_millideg,
   output logic               rsp_out_of_range,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_r0_milliohm
);

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // r0 register
   logic [23:0] r0_ff;
   always_ff @(posedge clock) begin
      if (reset) r0_ff <= R0Default;
      else if (csr_valid) r0_ff <= csr_r0_milliohm;
   end

   // stage one: magnitude times term
   logic        v1_ff, n1_ff;
   logic [QW-1:0] q1_ff;
   logic [23:0] r01_ff;
   logic [23:0] mag;
   assign mag = req_raw_code[23] ? 24'(-req_raw_code) : req_raw_code;
   always_ff @(posedge clock) begin
      q1_ff  <= QW'(CvdTerm) * QW'(mag);
      n1_ff  <= req_raw_code[23];
      r01_ff <= (r0_ff == '0) ? R0Default : r0_ff;
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
   end

   div_in_type  di;
   div_out_type dq;
   assign di.neg = n1_ff;
   assign di.q   = q1_ff;
   assign di.r0  = r01_ff;

   rtd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff),
      .in_data  (di),
      .out_data (dq)
   );

   // classify and form the radicand
   sq_in_type si_ff;
   always_ff @(posedge clock) begin
      si_ff.x <= dq.neg ? KQ28 + dq.tq : KQ28 - dq.tq;
      if (!dq.neg && (dq.big || dq.tq > KQ28)) begin
         si_ff.flag   <= 1'b1;
         si_ff.sel    <= 1'b1;
         si_ff.forced <= TErr;
      end else if (dq.neg && dq.big) begin
         si_ff.flag   <= 1'b0;
         si_ff.sel    <= 1'b1;
         si_ff.forced <= TMin;
      end else begin
         si_ff.flag   <= 1'b0;
         si_ff.sel    <= 1'b0;
         si_ff.forced <= TErr;
      end
      if (reset) si_ff.valid <= 1'b0;
      else si_ff.valid <= dq.valid;
   end

   rtd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_data   (si_ff),
      .out_valid (rsp_valid),
      .out_temp  (rsp_temp_millideg),
      .out_flag  (rsp_out_of_range)
   );

endmodule

// ===== verif/tb_rtd_adc_code_to_temperature_top.sv =====
// ----------------------------------------------------------------------------
// tb_rtd_adc_code_to_temperature_top: self-checking bench for the rtd block
// Drives ADC codes through the start/busy channel, predicts each temperature
// and range flag with an integer model of the inverse quadratic, and compares
// every strobed result in order. R0 is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_rtd_adc_code_to_temperature_top;

   // fixed-point constants of the inverse quadratic
   localparam logic [63:0] DiscK     = 64'd1758480889 << 28;
   localparam logic [63:0] TermScale = 64'd451171875;
   localparam longint      AScaled   = 64'sd39083 * 64'sd16384;
   localparam longint      TwoBDen   = 64'sd231 * 64'sd16384;
   localparam logic [63:0] OverLimit = 64'd1 << 34;
   localparam logic [23:0] R0Nominal = 24'd1000000;
   localparam longint      TempFloor = -64'sd4000000;
   localparam longint      TempCeil  = 64'sd4000000;
   localparam longint      TempError = -64'sd1000000;
   localparam int          DrainWait = 130;

   typedef struct packed {
      logic signed [22:0] temp;
      logic               oor;
   } temp_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [23:0] req_raw_code = '0;
   logic               rsp_valid;
   logic signed [22:0] rsp_temp_millideg;
   logic               rsp_out_of_range;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [23:0]        csr_r0_milliohm = '0;

   temp_result_type expected_temps[$];
   logic [23:0]  r0_shadow;
   int           mismatch_count = 0;
   int           gap_pct = 0;

   rtd_adc_code_to_temperature_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_code(req_raw_code), .rsp_valid(rsp_valid),
      .rsp_temp_millideg(rsp_temp_millideg), .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_r0_milliohm(csr_r0_milliohm)
   );

   always #5 clock = ~clock;

   // integer square root, floor
   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // temperature and range flag for one code at a given r0
   function automatic temp_result_type predict_temperature(logic [23:0] code,
                                                           logic [23:0] r0_reg);
      temp_result_type res;
      logic         neg;
      logic         over;
      logic [63:0]  mag, r0, prod, quo, rem, tq, disc;
      longint       num, n, t;
      neg  = code[23];
      mag  = neg ? (64'h1000000 - {40'b0, code}) : {40'b0, code};
      r0   = (r0_reg == 0) ? {40'b0, R0Nominal} : {40'b0, r0_reg};
      prod = TermScale * mag;
      quo  = prod / r0;
      rem  = prod % r0;
      over = quo > OverLimit;
      tq   = over ? 64'd0 : ((quo << 27) + ((rem << 27) / r0));
      res.oor = 1'b0;
      if (!neg && (over || tq > DiscK)) begin
         t = TempError;
         res.oor = 1'b1;
      end else if (neg && over) begin
         t = TempFloor;
      end else begin
         disc = neg ? DiscK + tq : DiscK - tq;
         num  = (AScaled - longint'(floor_sqrt(disc))) * 64'sd20000;
         n    = 2 * num + TwoBDen;
         t    = n / (2 * TwoBDen);
         if ((n % (2 * TwoBDen)) != 0 && n < 0) t = t - 1;
         if (t < TempFloor) t = TempFloor;
         if (t > TempCeil) t = TempCeil;
      end
      res.temp = t[22:0];
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("tb: mismatch %s at %0t", what, $realtime);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      temp_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_temps.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_temps.pop_front();
            if (rsp_temp_millideg !== want.temp)
               report_mismatch($sformatf("temp got %0d want %0d",
                                         rsp_temp_millideg, want.temp));
            if (rsp_out_of_range !== want.oor)
               report_mismatch($sformatf("out_of_range got %0b want %0b",
                                         rsp_out_of_range, want.oor));
         end
      end
   end

   // send one request, first idling each cycle with a chance of gap_pct percent; called at a falling edge
   task automatic send_code(logic [23:0] code);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_raw_code <= code;
      do @(posedge clock); while (busy);
      expected_temps.push_back(predict_temperature(code, r0_shadow));
      @(negedge clock);
   endtask

   // wait until every result has come, then let the pipeline empty
   task automatic drain_pipeline();
      start <= 1'b0;
      while (expected_temps.size() != 0) @(negedge clock);
      repeat (DrainWait) @(negedge clock);
   endtask

   task automatic write_r0(logic [23:0] value);
      drain_pipeline();
      csr_valid       <= 1'b1;
      csr_r0_milliohm <= value;
      do @(posedge clock); while (!csr_ready);
      r0_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] random_code();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($urandom_range(4194303));
         2: return -24'($urandom_range(2000000));
         default: return 24'($urandom_range(4000000, 3000000));
      endcase
   endfunction

   // extremes of the code at the reset r0
   task automatic test_code_extremes();
      logic [23:0] codes[$];
      codes = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
                24'h400000, 24'hC00000, 24'd1024000, 24'd3500000, 24'd3700000,
                24'd3800000, 24'h555555, 24'hAAAAAA};
      foreach (codes[i]) send_code(codes[i]);
   endtask

   // r0 at its extremes: zero selects nominal, tiny r0 overflows the term
   task automatic test_r0_extremes();
      logic [23:0] settings[$];
      settings = '{24'd0, 24'd1, 24'd16000000, 24'hFFFFFF};
      foreach (settings[i]) begin
         write_r0(settings[i]);
         send_code(24'h000000);
         send_code(24'h000040);
         send_code(24'hFFFFC0);
         send_code(24'h7FFFFF);
         send_code(24'h800000);
      end
   endtask

   // random codes over several r0 settings and gap modes
   task automatic test_random_codes();
      logic [23:0] settings[$];
      int          gaps[3];
      settings = '{R0Nominal, 24'd0, 24'd100000, 24'd16000000, 24'd1,
                   24'hFFFFFF, 24'($urandom_range(16000000)), R0Nominal, 24'd500000};
      gaps = '{26, 69, 0};
      foreach (settings[i]) begin
         write_r0(settings[i]);
         gap_pct = gaps[i / 3];
         for (int k = 0; k < 75; k++) begin
            send_code(random_code());
            if (i == 2 && k == 40) drain_pipeline();
         end
      end
   endtask

   initial begin
      r0_shadow = R0Nominal;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_code_extremes();
      test_r0_extremes();
      test_random_codes();
      drain_pipeline();
      if (mismatch_count == 0 && expected_temps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
